[rtl/core/jls_pkg.sv]
// jacobi linear solver: shared types, command codes and constants
// used by the controller, the datapath and the divider; no dependencies
`default_nettype none

package jls_pkg;

    localparam int DW     = 32;   // q16.16 data width
    localparam int IDX_W  = 5;    // loop index width, holds 0..16
    localparam int OP_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 31;

    localparam logic [DW-1:0] ONE_Q16 = 32'h0001_0000;
    localparam int DIV_STEPS = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

    // input kinds
    localparam logic OPK_LOAD  = 1'b0;
    localparam logic OPK_START = 1'b1;

    // result status codes
    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

    // datapath commands
    localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
    localparam logic [OP_W-1:0] OP_START     = 5'd2;
    localparam logic [OP_W-1:0] OP_NORM_CLR  = 5'd3;
    localparam logic [OP_W-1:0] OP_RD_MAT    = 5'd4;
    localparam logic [OP_W-1:0] OP_RD_BOTH   = 5'd5;
    localparam logic [OP_W-1:0] OP_MUL_SQ    = 5'd6;
    localparam logic [OP_W-1:0] OP_NORM_ACC  = 5'd7;
    localparam logic [OP_W-1:0] OP_DOM_CHK   = 5'd8;
    localparam logic [OP_W-1:0] OP_VEC_INIT  = 5'd9;
    localparam logic [OP_W-1:0] OP_MUL_TOL   = 5'd10;
    localparam logic [OP_W-1:0] OP_SW_BEGIN  = 5'd11;
    localparam logic [OP_W-1:0] OP_ROW_BEGIN = 5'd12;
    localparam logic [OP_W-1:0] OP_MUL_AX    = 5'd13;
    localparam logic [OP_W-1:0] OP_SUM_ACC   = 5'd14;
    localparam logic [OP_W-1:0] OP_NUM       = 5'd15;
    localparam logic [OP_W-1:0] OP_DIV_Q     = 5'd16;
    localparam logic [OP_W-1:0] OP_XNEW      = 5'd17;
    localparam logic [OP_W-1:0] OP_DIV_R     = 5'd18;
    localparam logic [OP_W-1:0] OP_RATIO     = 5'd19;
    localparam logic [OP_W-1:0] OP_MUL_RR    = 5'd20;
    localparam logic [OP_W-1:0] OP_ACC       = 5'd21;
    localparam logic [OP_W-1:0] OP_SW_END    = 5'd22;
    localparam logic [OP_W-1:0] OP_FINISH    = 5'd23;
    localparam logic [OP_W-1:0] OP_RD_OUT    = 5'd24;
    localparam logic [OP_W-1:0] OP_OUT_LD    = 5'd25;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] sz;        // unknowns in use
        logic             div_done;
        logic             zero_diag;
        logic             more;      // another sweep is needed
        logic             out_free;
    } t_sts;

endpackage

`default_nettype wire

[rtl/core/jacobi_linear_solver_top.sv]
// jacobi linear solver top level: stream ports, config port, controller and datapath
// depends on jls_pkg, jls_ctrl, jls_dp, jls_div
//
// usage: load beats (tuser 0) write one element a[row][col] of the augmented matrix,
// column size holds the right-hand side; loads stream back to back. a start beat (tuser 1)
// checks every row for diagonal dominance, sets all unknowns to 1.0 and, unless a
// diagonal element is zero, runs jacobi sweeps until the squared relative change
// is within tolerance or the sweep limit is hit, then sends one result beat
// per unknown, tlast on the final one. s_axis_tready is low from the start beat
// until the final result beat is loaded into the output register.
// each sweep runs, per row, the single-port matrix reads and shared multiplier
// products for the sum, then two 64-step bit-serial divisions.
// a stalled receiver holds the output register and the sequencer waits on it.
// config port always ready; the user must write it only while the block is idle (not enforced).
// reset restores size 16, tolerance 66, limit 3000; matrix contents are undefined.
`default_nettype none

module jacobi_linear_solver_top import jls_pkg::*; #(
    parameter int MAX_UNKNOWNS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0]    i_cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [47:0]          s_axis_tdata,   // row[3:0], col[8:4], value[40:9], zero
    input  wire logic                 s_axis_tuser,   // op
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [55:0]               m_axis_tdata,   // index[3:0], solution[35:4], sweeps[51:36]
    output logic                      m_axis_tlast,
    output logic [2:0]                m_axis_tuser    // status[1:0], dominant[2]
);

    t_cmd cmd;
    t_sts sts;

    logic [3:0]    o_idx;
    logic [DW-1:0] o_sol;
    logic [1:0]    o_stat;
    logic          o_dom;
    logic [15:0]   o_sw;

    assign o_cfg_ready = 1'b1;

    jls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    jls_dp #(
        .MAX_UNKNOWNS (MAX_UNKNOWNS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_row       (s_axis_tdata[3:0]),
        .i_col       (s_axis_tdata[8:4]),
        .i_value     (s_axis_tdata[40:9]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_index     (o_idx),
        .o_solution  (o_sol),
        .o_last      (m_axis_tlast),
        .o_status    (o_stat),
        .o_dominant  (o_dom),
        .o_sweeps    (o_sw)
    );

    assign m_axis_tdata = {4'b0, o_sw, o_sol, o_idx};
    assign m_axis_tuser = {o_dom, o_stat};

endmodule

`default_nettype wire

[rtl/core/jls_div.sv]
// jacobi linear solver: 64 by 32 bit unsigned restoring divider, one bit a cycle
// depends on jls_pkg for the step count
`default_nettype none

module jls_div import jls_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [63:0]      o_quotient
);

    localparam int CW = $clog2(DIV_STEPS);

    logic [32:0]   r_rem;
    logic [63:0]   r_quo;
    logic [31:0]   r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [32:0] rem_sh;
    logic        ge;

    assign rem_sh = {r_rem[31:0], r_quo[63]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            r_quo <= {r_quo[62:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

[rtl/core/jls_dp.sv]
// jacobi linear solver datapath: config registers, matrix memory, vector banks,
// shared multiplier, divider and result register; uses jls_pkg and jls_div
`default_nettype none

module jls_dp import jls_pkg::*; #(
    parameter int MAX_UNKNOWNS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0]    i_cfg_data,
    input  wire logic [3:0]           i_row,
    input  wire logic [4:0]           i_col,
    input  wire logic [DW-1:0]        i_value,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [3:0]                o_index,
    output logic [DW-1:0]             o_solution,
    output logic                      o_last,
    output logic [1:0]                o_status,
    output logic                      o_dominant,
    output logic [15:0]               o_sweeps
);

    localparam int COLS      = MAX_UNKNOWNS + 1;
    localparam int MAT_DEPTH = MAX_UNKNOWNS * COLS;
    localparam int MAW       = $clog2(MAT_DEPTH);
    localparam int VD        = (MAX_UNKNOWNS < 16) ? MAX_UNKNOWNS : 16;
    localparam int VAW       = $clog2(VD);
    localparam logic [IDX_W-1:0] CAP = IDX_W'(VD);

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) sat_add64 = s[64] ? 64'h8000_0000_0000_0000
                                              : 64'h7FFF_FFFF_FFFF_FFFF;
        else                sat_add64 = s[63:0];
    endfunction

    function automatic logic [63:0] sat_sub64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) sat_sub64 = s[64] ? 64'h8000_0000_0000_0000
                                              : 64'h7FFF_FFFF_FFFF_FFFF;
        else                sat_sub64 = s[63:0];
    endfunction

    // config
    logic [4:0]  r_size;
    logic [30:0] r_tol;
    logic [15:0] r_limit;

    // storage
    logic [DW-1:0] r_mat [MAT_DEPTH];
    logic [DW-1:0] r_vec [2][VD];
    logic [DW-1:0] r_rdata;
    logic [DW-1:0] r_vrd;
    logic          r_sel;

    // working registers
    logic [63:0]      r_mul;
    logic [63:0]      r_norm;
    logic [62:0]      r_dsq;
    logic [DW-1:0]    r_diag;
    logic [IDX_W-1:0] r_dom_cnt;
    logic             r_zd;
    logic [61:0]      r_tolsq;
    logic [63:0]      r_sum;
    logic [63:0]      r_num;
    logic             r_neg;
    logic [DW-1:0]    r_xold;
    logic [DW-1:0]    r_xnew;
    logic             r_axn_zero;
    logic [23:0]      r_ratio;
    logic [47:0]      r_acc;
    logic [15:0]      r_sweeps;
    logic [1:0]       r_status;

    // result register
    logic          r_ovalid;
    logic [3:0]    r_oidx;
    logic [DW-1:0] r_osol;
    logic          r_olast;
    logic [1:0]    r_ostat;
    logic          r_odom;
    logic [15:0]   r_osw;

    logic [IDX_W-1:0] sz;
    logic             is_diag;
    logic             load_ok;
    logic [MAW-1:0]   mat_waddr;
    logic [MAW-1:0]   mat_raddr;
    logic signed [32:0] rd_ext;
    logic signed [32:0] rd_mag;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic [32:0]  xdiff;
    logic [32:0]  ad;
    logic [31:0]  axn;
    logic         div_start;
    logic [63:0]  div_dividend;
    logic [31:0]  div_divisor;
    logic         div_done;
    logic [63:0]  div_quo;
    logic [DW-1:0] xnew;
    logic [64:0]  norm_s;
    logic [48:0]  acc_s;
    logic         conv;

    assign sz = (r_size == '0) ? IDX_W'(1) : ((r_size > CAP) ? CAP : r_size);
    assign is_diag = i_cmd.i == i_cmd.j;

    assign load_ok   = (32'(i_row) < 32'(MAX_UNKNOWNS)) && (32'(i_col) <= 32'(MAX_UNKNOWNS));
    assign mat_waddr = MAW'(i_row) * MAW'(COLS) + MAW'(i_col);
    assign mat_raddr = MAW'(i_cmd.i) * MAW'(COLS) + MAW'(i_cmd.j);

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && load_ok) r_mat[mat_waddr] <= i_value;
        if (i_cmd.op == OP_RD_MAT || i_cmd.op == OP_RD_BOTH) r_rdata <= r_mat[mat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_VEC_INIT) r_vec[r_sel][i_cmd.i[VAW-1:0]] <= ONE_Q16;
        if (i_cmd.op == OP_XNEW)     r_vec[~r_sel][i_cmd.i[VAW-1:0]] <= xnew;
        if (i_cmd.op == OP_RD_BOTH)  r_vrd <= r_vec[r_sel][i_cmd.j[VAW-1:0]];
        if (i_cmd.op == OP_RD_OUT)   r_vrd <= r_vec[r_sel][i_cmd.i[VAW-1:0]];
    end

    // shared multiplier
    assign rd_ext = {r_rdata[31], r_rdata};
    assign rd_mag = r_rdata[31] ? -rd_ext : rd_ext;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_MUL_SQ: begin
                mul_a = rd_mag;
                mul_b = rd_mag;
            end
            OP_MUL_AX: begin
                mul_a = rd_ext;
                mul_b = {r_vrd[31], r_vrd};
            end
            OP_MUL_RR: begin
                mul_a = {9'b0, r_ratio};
                mul_b = {9'b0, r_ratio};
            end
            OP_MUL_TOL: begin
                mul_a = {2'b0, r_tol};
                mul_b = {2'b0, r_tol};
            end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // divider operands
    assign xdiff = {r_xnew[31], r_xnew} - {r_xold[31], r_xold};
    assign ad    = xdiff[32] ? -xdiff : xdiff;
    assign axn   = r_xnew[31] ? -r_xnew : r_xnew;

    assign div_start = (i_cmd.op == OP_DIV_Q) || (i_cmd.op == OP_DIV_R);
    always_comb begin
        if (i_cmd.op == OP_DIV_R) begin
            div_dividend = {15'b0, ad, 16'b0};
            div_divisor  = axn;
        end else begin
            div_dividend = r_num[63] ? -r_num : r_num;
            div_divisor  = r_diag[31] ? -r_diag : r_diag;
        end
    end

    jls_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // quotient to q16.16 with saturation
    always_comb begin
        if (r_neg) xnew = (div_quo[63:31] != '0) ? 32'h8000_0000 : -div_quo[31:0];
        else       xnew = (div_quo[63:31] != '0) ? 32'h7FFF_FFFF : div_quo[31:0];
    end

    assign norm_s = {1'b0, r_norm} + {1'b0, r_mul};
    assign acc_s  = {1'b0, r_acc} + {1'b0, r_mul[47:0]};
    assign conv   = {14'b0, r_acc} <= r_tolsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= 5'd16;
            r_tol     <= 31'd66;
            r_limit   <= 16'd3000;
            r_sel     <= 1'b0;
            r_dom_cnt <= '0;
            r_zd      <= 1'b0;
            r_acc     <= '0;
            r_sweeps  <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SIZE:  r_size  <= i_cfg_data[4:0];
                    CFG_TOL:   r_tol   <= i_cfg_data;
                    CFG_LIMIT: r_limit <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_OUT_LD)  r_ovalid <= 1'b1;
            else if (i_out_ready)       r_ovalid <= 1'b0;

            unique case (i_cmd.op)
                OP_START: begin
                    r_dom_cnt <= '0;
                    r_zd      <= 1'b0;
                    r_acc     <= '0;
                    r_sweeps  <= '0;
                end
                OP_DOM_CHK: begin
                    if (!r_diag[31] && r_diag != '0 && {1'b0, r_dsq} > r_norm)
                        r_dom_cnt <= r_dom_cnt + 1'b1;
                    if (r_diag == '0) r_zd <= 1'b1;
                end
                OP_SW_BEGIN: r_acc <= '0;
                OP_ACC:      r_acc <= acc_s[48] ? '1 : acc_s[47:0];
                OP_SW_END: begin
                    r_sel    <= ~r_sel;
                    r_sweeps <= r_sweeps + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_MUL_SQ, OP_MUL_AX, OP_MUL_RR: r_mul <= mul_p[63:0];
            OP_MUL_TOL:   r_tolsq <= mul_p[61:0];
            OP_NORM_CLR:  r_norm  <= '0;
            OP_NORM_ACC: begin
                if (is_diag) begin
                    r_diag <= r_rdata;
                    r_dsq  <= r_mul[62:0];
                end else begin
                    r_norm <= norm_s[64] ? '1 : norm_s[63:0];
                end
            end
            OP_ROW_BEGIN: r_sum <= '0;
            OP_SUM_ACC: begin
                if (is_diag) begin
                    r_diag <= r_rdata;
                    r_xold <= r_vrd;
                end else begin
                    r_sum <= sat_add64(r_sum, r_mul);
                end
            end
            OP_NUM:   r_num <= sat_sub64({{16{r_rdata[31]}}, r_rdata, 16'b0}, r_sum);
            OP_DIV_Q: r_neg <= r_num[63] ^ r_diag[31];
            OP_XNEW:  r_xnew <= xnew;
            OP_DIV_R: r_axn_zero <= r_xnew == '0;
            OP_RATIO: r_ratio <= (r_axn_zero || div_quo[63:24] != '0) ? 24'hFF_FFFF
                                                                      : div_quo[23:0];
            OP_FINISH: r_status <= r_zd ? ST_ZERO_DIAG : (conv ? ST_CONVERGED : ST_LIMIT);
            OP_OUT_LD: begin
                r_oidx  <= i_cmd.i[3:0];
                r_osol  <= r_vrd;
                r_olast <= i_cmd.i == (sz - 1'b1);
                r_ostat <= r_status;
                r_odom  <= r_dom_cnt == sz;
                r_osw   <= r_sweeps;
            end
            default: ;
        endcase
    end

    assign o_sts.sz        = sz;
    assign o_sts.div_done  = div_done;
    assign o_sts.zero_diag = r_zd;
    assign o_sts.more      = !conv && (r_sweeps < r_limit);
    assign o_sts.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_index     = r_oidx;
    assign o_solution  = r_osol;
    assign o_last      = r_olast;
    assign o_status    = r_ostat;
    assign o_dominant  = r_odom;
    assign o_sweeps    = r_osw;

endmodule

`default_nettype wire

[rtl/core/jls_ctrl.sv]
// jacobi linear solver controller: sequences dominance check, sweeps and result beats
// drives jls_dp through t_cmd and reads t_sts; uses jls_pkg
`default_nettype none

module jls_ctrl import jls_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_op,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DOM_CLR   = 5'd1;
    localparam logic [4:0] S_DOM_RD    = 5'd2;
    localparam logic [4:0] S_DOM_MUL   = 5'd3;
    localparam logic [4:0] S_DOM_ACC   = 5'd4;
    localparam logic [4:0] S_DOM_CHK   = 5'd5;
    localparam logic [4:0] S_INIT      = 5'd6;
    localparam logic [4:0] S_TOL       = 5'd7;
    localparam logic [4:0] S_SW_BEGIN  = 5'd8;
    localparam logic [4:0] S_ROW_BEGIN = 5'd9;
    localparam logic [4:0] S_SW_RD     = 5'd10;
    localparam logic [4:0] S_SW_MUL    = 5'd11;
    localparam logic [4:0] S_SW_ACC    = 5'd12;
    localparam logic [4:0] S_B_RD      = 5'd13;
    localparam logic [4:0] S_NUM       = 5'd14;
    localparam logic [4:0] S_DIVQ_GO   = 5'd15;
    localparam logic [4:0] S_DIVQ_WAIT = 5'd16;
    localparam logic [4:0] S_XNEW      = 5'd17;
    localparam logic [4:0] S_DIVR_GO   = 5'd18;
    localparam logic [4:0] S_DIVR_WAIT = 5'd19;
    localparam logic [4:0] S_RATIO     = 5'd20;
    localparam logic [4:0] S_RR        = 5'd21;
    localparam logic [4:0] S_ACC       = 5'd22;
    localparam logic [4:0] S_SW_END    = 5'd23;
    localparam logic [4:0] S_CHECK     = 5'd24;
    localparam logic [4:0] S_FINISH    = 5'd25;
    localparam logic [4:0] S_OUT_RD    = 5'd26;
    localparam logic [4:0] S_OUT_LD    = 5'd27;

    logic [4:0]       r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] last;
    logic             i_last;
    logic             j_last;

    assign last   = i_sts.sz - 1'b1;
    assign i_last = r_i == last;
    assign j_last = r_j == last;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        op      = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op == OPK_START) begin
                        op      = OP_START;
                        n_i     = '0;
                        n_state = S_DOM_CLR;
                    end else begin
                        op = OP_LOAD;
                    end
                end
            end
            S_DOM_CLR: begin
                op      = OP_NORM_CLR;
                n_j     = '0;
                n_state = S_DOM_RD;
            end
            S_DOM_RD: begin
                op      = OP_RD_MAT;
                n_state = S_DOM_MUL;
            end
            S_DOM_MUL: begin
                op      = OP_MUL_SQ;
                n_state = S_DOM_ACC;
            end
            S_DOM_ACC: begin
                op = OP_NORM_ACC;
                if (j_last) n_state = S_DOM_CHK;
                else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_DOM_RD;
                end
            end
            S_DOM_CHK: begin
                op = OP_DOM_CHK;
                if (i_last) begin
                    n_i     = '0;
                    n_state = S_INIT;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_DOM_CLR;
                end
            end
            S_INIT: begin
                op = OP_VEC_INIT;
                if (i_last) n_state = S_TOL;
                else        n_i = r_i + 1'b1;
            end
            S_TOL: begin
                op  = OP_MUL_TOL;
                n_i = '0;
                n_state = i_sts.zero_diag ? S_FINISH : S_SW_BEGIN;
            end
            S_SW_BEGIN: begin
                op      = OP_SW_BEGIN;
                n_i     = '0;
                n_state = S_ROW_BEGIN;
            end
            S_ROW_BEGIN: begin
                op      = OP_ROW_BEGIN;
                n_j     = '0;
                n_state = S_SW_RD;
            end
            S_SW_RD: begin
                op      = OP_RD_BOTH;
                n_state = S_SW_MUL;
            end
            S_SW_MUL: begin
                op      = OP_MUL_AX;
                n_state = S_SW_ACC;
            end
            S_SW_ACC: begin
                op = OP_SUM_ACC;
                if (j_last) begin
                    n_j     = i_sts.sz;   // right-hand side column
                    n_state = S_B_RD;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_SW_RD;
                end
            end
            S_B_RD: begin
                op      = OP_RD_MAT;
                n_state = S_NUM;
            end
            S_NUM: begin
                op      = OP_NUM;
                n_state = S_DIVQ_GO;
            end
            S_DIVQ_GO: begin
                op      = OP_DIV_Q;
                n_state = S_DIVQ_WAIT;
            end
            S_DIVQ_WAIT: begin
                if (i_sts.div_done) n_state = S_XNEW;
            end
            S_XNEW: begin
                op      = OP_XNEW;
                n_state = S_DIVR_GO;
            end
            S_DIVR_GO: begin
                op      = OP_DIV_R;
                n_state = S_DIVR_WAIT;
            end
            S_DIVR_WAIT: begin
                if (i_sts.div_done) n_state = S_RATIO;
            end
            S_RATIO: begin
                op      = OP_RATIO;
                n_state = S_RR;
            end
            S_RR: begin
                op      = OP_MUL_RR;
                n_state = S_ACC;
            end
            S_ACC: begin
                op = OP_ACC;
                if (i_last) n_state = S_SW_END;
                else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_ROW_BEGIN;
                end
            end
            S_SW_END: begin
                op      = OP_SW_END;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_sts.more ? S_SW_BEGIN : S_FINISH;
            end
            S_FINISH: begin
                op      = OP_FINISH;
                n_i     = '0;
                n_state = S_OUT_RD;
            end
            S_OUT_RD: begin
                op      = OP_RD_OUT;
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                if (i_sts.out_free) begin
                    op = OP_OUT_LD;
                    if (i_last) n_state = S_IDLE;
                    else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    assign o_in_ready = r_state == S_IDLE;
    assign o_cmd.op   = op;
    assign o_cmd.i    = r_i;
    assign o_cmd.j    = r_j;

    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op == OP_OUT_LD |-> i_sts.out_free)
        else $error("result beat loaded over a pending one");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_i < i_sts.sz)
        else $error("row index beyond system size");

    a_div_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_DIVQ_WAIT || r_state == S_DIVR_WAIT))
        else $error("divider finished outside a wait state");

endmodule

`default_nettype wire
